@@ hw/rtl/mal_pkg.sv @@
// Shared types and constants for the moving-average low-pass filter.
// No dependencies; imported by every module of the block but mal_ram.
package mal_pkg;

  // width of the window-length configuration word
  localparam int CFG_BITS = 13;

  // status of the queue between front and back
  typedef struct packed {
    logic empty;
    logic full;
  } mal_qstat_t;

endpackage

@@ hw/rtl/mal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4095,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/mal_queue.sv @@
// Short register queue that decouples the front end from the divider.
// Depends on mal_pkg for the status struct.
module mal_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    pop,
  output logic [WIDTH-1:0]        rdata,
  output mal_pkg::mal_qstat_t     stat
);
  import mal_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNTW-1:0]  count;

  assign stat.full  = (count == CNTW'(DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/mal_front.sv @@
// Front end: accepts samples, keeps the running sum and the delay store,
// and queues the dividend for each word. Depends on mal_pkg and mal_ram.
module mal_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 4096,
  localparam int NW       = $clog2(MAX_WINDOW + 1),
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [NW-1:0]              window,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                       push,
  output logic                       full,
  input  mal_pkg::mal_qstat_t        qstat,
  output logic                       q_push,
  output logic signed [SUM_BITS-1:0] q_data
);
  import mal_pkg::*;

  localparam int DEPTH = MAX_WINDOW - 1;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

  state_t                        state;
  logic signed [SUM_BITS-1:0]    sum;
  logic [IW-1:0]                 idx;
  logic                          wrapped;
  logic signed [SAMPLE_BITS-1:0] held;
  logic signed [SAMPLE_BITS-1:0] old_rdata;
  logic signed [SAMPLE_BITS-1:0] old;
  logic                          accept;
  logic                          pass;
  logic                          last;

  assign full   = (state != ST_IDLE) || qstat.full;
  assign accept = push && !full;
  assign pass   = (window == NW'(1));
  assign q_push = accept;
  assign q_data = pass ? SUM_BITS'(sample) : sum + SUM_BITS'(sample);
  // entries not yet written since the last clear read as zero
  assign old    = wrapped ? old_rdata : '0;
  assign last   = (NW'(idx) == window - NW'(2));

  mal_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (idx),
    .wdata (held),
    .raddr (idx),
    .rdata (old_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state   <= ST_IDLE;
      sum     <= '0;
      idx     <= '0;
      wrapped <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && !pass) begin
            sum   <= q_data;
            held  <= sample;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum   <= sum - SUM_BITS'(old);
          idx   <= last ? '0 : idx + IW'(1);
          if (last) begin
            wrapped <= 1'b1;
          end
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_update_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> $past(accept && !pass))
    else $error("front update without an accepted word");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !pass |-> (NW'(idx) < window - NW'(1)))
    else $error("write index beyond window depth");
`endif

endmodule

@@ hw/rtl/mal_back.sv @@
// Back end: restoring divider, one quotient bit per cycle, and result register.
// Depends on mal_pkg for the queue status struct.
module mal_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 4096,
  localparam int NW       = $clog2(MAX_WINDOW + 1),
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [NW-1:0]                 window,
  input  mal_pkg::mal_qstat_t           qstat,
  input  logic signed [SUM_BITS-1:0]    q_data,
  output logic                          q_pop,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic                          empty,
  input  logic                          pop
);
  import mal_pkg::*;

  localparam int CW = $clog2(SUM_BITS);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

  state_t                 state;
  logic                   neg;
  logic [SUM_BITS-1:0]    quo;
  logic [NW-1:0]          rem;
  logic [CW-1:0]          cnt;
  logic [SUM_BITS-1:0]    mag;
  logic [NW:0]            trial;
  logic [NW:0]            diff;
  logic                   ge;
  logic [NW-1:0]          rem_next;
  logic [SUM_BITS-1:0]    quo_next;
  logic [SAMPLE_BITS-1:0] res_mag;
  logic [SAMPLE_BITS-1:0] result;

  assign q_pop = (state == ST_IDLE) && !qstat.empty;
  assign empty = (state != ST_HOLD);

  // divide the magnitude, then restore the sign: truncates toward zero
  assign mag      = q_data[SUM_BITS-1] ? (~q_data + 1'b1) : q_data;
  assign trial    = {rem, quo[SUM_BITS-1]};
  assign diff     = trial - {1'b0, window};
  assign ge       = (trial >= {1'b0, window});
  assign rem_next = ge ? diff[NW-1:0] : trial[NW-1:0];
  assign quo_next = {quo[SUM_BITS-2:0], ge};
  assign res_mag  = quo_next[SAMPLE_BITS-1:0];
  assign result   = neg ? (~res_mag + 1'b1) : res_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            neg   <= q_data[SUM_BITS-1];
            quo   <= mag;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(SUM_BITS - 1)) begin
            average <= result;
            state   <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (pop) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < window))
    else $error("divider remainder not below divisor");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !pop) |=> (state == ST_HOLD) && $stable(average))
    else $error("waiting result changed before pop");
`endif

endmodule

@@ hw/rtl/moving_average_lowpass.sv @@
// Boxcar moving-average low-pass filter, signed samples in and mean out.
// Each word passes through the front end, the queue and the bit-serial divider.
// The divider takes a new word only once its result is popped; the front end refuses
// samples while it updates the sum and store, or while the two-entry queue is full.
// Reset (rst, synchronous) and every window write clear the sum, index and history
// at once; the delay store itself is not swept, unwritten entries read as zero.
module moving_average_lowpass #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mal_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             push,
  output logic                             full,
  output logic signed [SAMPLE_BITS-1:0]    average,
  output logic                             empty,
  input  logic                             pop
);
  import mal_pkg::*;

  localparam int NW       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

  logic [NW-1:0]              window;
  logic [NW-1:0]              window_next;
  logic                       f_push;
  logic signed [SUM_BITS-1:0] f_data;
  logic [SUM_BITS-1:0]        b_data;
  logic                       b_pop;
  mal_qstat_t                 qstat;

  // zero means one, lengths above MAX_WINDOW saturate to it
  always_comb begin
    if (cfg_data == '0) begin
      window_next = NW'(1);
    end else if (32'(cfg_data) > MAX_WINDOW) begin
      window_next = NW'(MAX_WINDOW);
    end else begin
      window_next = NW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= NW'(1);
    end else if (cfg_write) begin
      window <= window_next;
    end
  end

  mal_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_write),
    .window (window),
    .sample (sample),
    .push   (push),
    .full   (full),
    .qstat  (qstat),
    .q_push (f_push),
    .q_data (f_data)
  );

  mal_queue #(
    .WIDTH (SUM_BITS),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst || cfg_write),
    .push  (f_push),
    .wdata (f_data),
    .pop   (b_pop),
    .rdata (b_data),
    .stat  (qstat)
  );

  mal_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .window  (window),
    .qstat   (qstat),
    .q_data  (b_data),
    .q_pop   (b_pop),
    .average (average),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

@@ tb/moving_average_lowpass_checker.sv @@
// Checker for the boxcar low-pass filter: watches the config, sample and average channels,
// keeps its own copy of the window state, predicts each average and compares in order.
// Depends on mal_pkg for the config word width.
module moving_average_lowpass_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mal_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] average,
  input  logic                          empty,
  input  logic                          pop,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mal_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic [CFG_BITS-1:0]          win_len;
  sample_t                      delay_line [MAX_WINDOW-1];
  logic signed [SUM_BITS-1:0]   box_sum;
  int unsigned                  tap_idx;
  sample_t                      mean_q [$];

  function automatic void clear_window();
    foreach (delay_line[i]) delay_line[i] = '0;
    box_sum = '0;
    tap_idx = 0;
  endfunction

  // zero acts as one, anything past MAX_WINDOW saturates to it
  function automatic void set_window(logic [CFG_BITS-1:0] value);
    if (value == 0) begin
      win_len = CFG_BITS'(1);
    end else if (value > MAX_WINDOW) begin
      win_len = CFG_BITS'(MAX_WINDOW);
    end else begin
      win_len = value;
    end
    clear_window();
  endfunction

  function automatic sample_t boxcar_mean(sample_t s);
    int unsigned depth;
    longint      quot;
    if (win_len <= 1) return s;
    depth = win_len - 1;
    if (tap_idx >= depth) tap_idx = 0;
    box_sum = box_sum + s;
    // signed division truncates toward zero
    quot = longint'(box_sum) / longint'(win_len);
    box_sum = box_sum - delay_line[tap_idx];
    delay_line[tap_idx] = s;
    tap_idx++;
    if (tap_idx >= depth) tap_idx = 0;
    return sample_t'(quot);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      set_window(CFG_BITS'(1));
      mean_q.delete();
      errors = 0;
    end else begin
      // compare before predicting so a word popped in the cycle of its own push cannot match its input
      if (pop && !empty) begin
        if (mean_q.size() == 0) begin
          if (errors < 10) $display("%t: average word %0d popped with none pending",
                                    $realtime, average);
          errors++;
        end else begin
          want = mean_q.pop_front();
          if (average !== want) begin
            if (errors < 10) $display("%t: average mismatch: expected %0d, got %0d",
                                      $realtime, want, average);
            errors++;
          end
        end
      end
      if (cfg_write) set_window(cfg_data);
      if (push && !full) mean_q.push_back(boxcar_mean(sample));
    end
    pending = mean_q.size();
  end

endmodule

@@ tb/moving_average_lowpass_tb.sv @@
// Top of the boxcar filter testbench: clock, reset, sample and pop drivers, window writes,
// watchdog and verdict. Needs moving_average_lowpass, mal_pkg and the checker module.
module moving_average_lowpass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 32;   // a bit past the block's push-to-result latency
  localparam int RANDOM_WORDS   = 700;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [mal_pkg::CFG_BITS-1:0] cfg_data  = '0;
  logic signed [15:0]           sample    = '0;
  logic                         push      = 1'b0;
  logic                         pop       = 1'b0;
  logic                         full;
  logic                         empty;
  logic signed [15:0]           average;

  int errors;
  int pending;
  int push_gap_odds  = 0;   // one-in-N chance of a gap burst before a word; 0 = none
  int pop_stall_odds = 0;
  int pop_hold       = 0;
  int idle_count     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  moving_average_lowpass dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .push      (push),
    .full      (full),
    .average   (average),
    .empty     (empty),
    .pop       (pop)
  );

  moving_average_lowpass_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .push      (push),
    .full      (full),
    .average   (average),
    .empty     (empty),
    .pop       (pop),
    .errors    (errors),
    .pending   (pending)
  );

  // result side: random stall bursts that hold pop low
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (pop_stall_odds != 0 && $urandom_range(0, pop_stall_odds - 1) == 0) begin
      pop_hold <= $urandom_range(0, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      idle_count <= 0;
    end else if (idle_count == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic signed [15:0] value);
    if (push_gap_odds != 0 && $urandom_range(0, push_gap_odds - 1) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    push <= 1'b1;
    sample <= value;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_window(input int value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value[mal_pkg::CFG_BITS-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(input int flavor);
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: begin
        case (flavor)
          1:       return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
          2:       return 16'($urandom_range(0, 16) - 8);
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin
    int words_left;
    int phase;
    int len;
    int win;
    int flavor;
    int odds_menu [4] = '{0, 3, 8, 20};

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    push_gap_odds = 4;
    pop_stall_odds = 4;

    // window of one after reset: pass-through
    send_word(32767);
    send_word(-32768);
    send_word(0);
    send_word(-1);
    send_word(1);
    // zero length behaves as one
    write_window(0);
    send_word(5);
    send_word(-7);
    // short window, truncation toward zero on odd negative sums
    write_window(2);
    send_word(-1);
    send_word(0);
    send_word(-32768);
    send_word(-32768);
    send_word(32767);
    send_word(32767);
    // all ones saturates to the longest window
    write_window(8191);
    send_word(-32768);
    send_word(-32768);
    send_word(32767);
    write_window(3);
    send_word(1);
    send_word(1);
    send_word(-2);
    send_word(-2);
    send_word(-2);
    send_word(7);
    write_window(4097);
    send_word(-32768);
    send_word(100);

    words_left = RANDOM_WORDS;
    phase = 0;
    while (words_left > 0) begin
      case (phase)
        0: win = 4095;
        1: win = 1;
        2: win = 2;
        3: win = 4096;
        default: begin
          case ($urandom_range(0, 5))
            0:       win = $urandom_range(0, 8191);
            1:       win = $urandom_range(1, 3);
            default: win = $urandom_range(4, 40);
          endcase
        end
      endcase
      write_window(win);
      len = $urandom_range(20, 80);
      if (len > words_left) len = words_left;
      // last stretch of the run runs with no push gaps or pop stalls
      if (words_left <= 100) begin
        len = words_left;
        push_gap_odds = 0;
        pop_stall_odds = 0;
      end else begin
        push_gap_odds = odds_menu[$urandom_range(0, 3)];
        pop_stall_odds = odds_menu[$urandom_range(0, 3)];
      end
      flavor = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && phase % 3 == 0 && words_left > 100) drain_results();
        send_word(pick_sample(flavor));
      end
      words_left -= len;
      phase++;
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
